[hw/rtl/rfwd_pkg.sv]
// shared types, constants and helper functions of the receiver float word decoder
`timescale 1ns / 1ps
package rfwd_pkg;

  localparam int WordW     = 32;
  localparam int MantW     = 26;
  localparam int AvgW      = 13;
  localparam int ProdW     = MantW + AvgW;
  localparam int HalfLoW   = 20;
  localparam int HalfHiW   = ProdW - HalfLoW;
  localparam int SqW       = 2 * ProdW;
  localparam int NormW     = 142;
  localparam int RadW      = 62;
  localparam int RootW     = RadW / 2;
  localparam int RemW      = RootW + 2;
  localparam int MagW      = 40;
  localparam int SqrtStages = RootW;
  localparam int ExpBias   = 127;
  localparam int CfgDataW  = AvgW;
  localparam int CfgIndexW = 1;

  // exponent offset of the magnitude radicand window (t2 = NormW - RadW - shift)
  localparam int MagExpBase = (NormW - RadW) / 2 + 19;

  typedef enum logic [1:0] {
    MODE_WAVE = 2'd0,
    MODE_SPEC = 2'd1,
    MODE_CORR = 2'd2,
    MODE_MAG  = 2'd3
  } mode_t;

  localparam logic [CfgIndexW-1:0] CFG_IDX_MODE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_IDX_AVG  = 1'b1;

  // per-item sideband that travels with the radicand
  typedef struct packed {
    logic              last;
    logic              is_mag;
    logic              neg;
    logic              sticky;
    logic signed [7:0] e2;
    logic [MagW-1:0]   mag;
  } side_t;

  // leading zero count of the wide sum of squares
  function automatic logic [7:0] lzc_norm(input logic [NormW-1:0] x);
    logic [7:0] n;
    n = 8'(NormW);
    for (int i = 0; i < NormW; i++) begin
      if (x[i]) n = 8'(NormW - 1 - i);
    end
    return n;
  endfunction

  // leading zero count of the value to pack
  function automatic logic [5:0] lzc_mag(input logic [MagW-1:0] x);
    logic [5:0] n;
    n = 6'(MagW);
    for (int i = 0; i < MagW; i++) begin
      if (x[i]) n = 6'(MagW - 1 - i);
    end
    return n;
  endfunction

endpackage

[hw/rtl/rfwd_if.sv]
// request channel interfaces of the receiver float word decoder
`timescale 1ns / 1ps
interface rfwd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] primary_word;
  logic [31:0] secondary_word;
  logic        end_of_spectrum;

  modport source(output valid, output primary_word, output secondary_word,
                 output end_of_spectrum, input ready);
  modport sink(input valid, input primary_word, input secondary_word,
               input end_of_spectrum, output ready);
endinterface

interface rfwd_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  logic        last_channel;

  modport source(output valid, output float_bits, output last_channel, input ready);
  modport sink(input valid, input float_bits, input last_channel, output ready);
endinterface

[hw/rtl/rfwd_sqrt.sv]
// pipelined integer square root, one root bit per stage, with sideband
`timescale 1ns / 1ps
module rfwd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rfwd_pkg::RadW-1:0]   in_rad,
  input  rfwd_pkg::side_t             in_side,
  output logic                        out_valid,
  output logic [rfwd_pkg::RootW-1:0]  out_root,
  output logic                        out_rem_nz,
  output rfwd_pkg::side_t             out_side
);

  localparam int N = rfwd_pkg::SqrtStages;

  logic                       vld  [1:N];
  logic [rfwd_pkg::RadW-1:0]  rad  [1:N];
  logic [rfwd_pkg::RootW-1:0] root [1:N];
  logic [rfwd_pkg::RemW-1:0]  rem  [1:N];
  rfwd_pkg::side_t            side [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                       v_in;
    logic [rfwd_pkg::RadW-1:0]  r_in;
    logic [rfwd_pkg::RootW-1:0] q_in;
    logic [rfwd_pkg::RemW-1:0]  m_in;
    rfwd_pkg::side_t            s_in;
    logic [rfwd_pkg::RemW+1:0]  cur;
    logic [rfwd_pkg::RemW+1:0]  trial;
    logic                       fits;

    // stage zero takes the incoming request
    if (i == 0) begin : g_head
      assign v_in = in_valid;
      assign r_in = in_rad;
      assign q_in = '0;
      assign m_in = '0;
      assign s_in = in_side;
    end else begin : g_body
      assign v_in = vld[i];
      assign r_in = rad[i];
      assign q_in = root[i];
      assign m_in = rem[i];
      assign s_in = side[i];
    end

    // bring down two radicand bits and try the next root bit
    assign cur   = {m_in, r_in[rfwd_pkg::RadW-1 -: 2]};
    assign trial = {2'b00, q_in, 2'b01};
    assign fits  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= {r_in[rfwd_pkg::RadW-3:0], 2'b00};
        root[i+1] <= {q_in[rfwd_pkg::RootW-2:0], fits};
        rem[i+1]  <= fits ? rfwd_pkg::RemW'(cur - trial) : rfwd_pkg::RemW'(cur);
        side[i+1] <= s_in;
      end
    end
  end

  assign out_valid  = vld[N];
  assign out_root   = root[N];
  assign out_rem_nz = rem[N] != '0;
  assign out_side   = side[N];

endmodule

[hw/rtl/receiver_float_word_decoder.sv]
// receiver float word decoder: receiver words to single-precision bit patterns
// pipeline: 8 front stages, 31 square root stages and 2 packing stages,
//   the same in every mode
// throughput: one request per cycle; the whole pipeline advances when the
//   output register is empty or its request is taken
// reset: synchronous, clears all valid bits; decode_mode and averaged_spectra
//   return to 1
`timescale 1ns / 1ps
module receiver_float_word_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rfwd_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [rfwd_pkg::CfgDataW-1:0]   cfg_data,
  rfwd_word_if.sink                       word,
  rfwd_result_if.source                   result
);

  localparam int ProdW = rfwd_pkg::ProdW;
  localparam int LoW   = rfwd_pkg::HalfLoW;
  localparam int HiW   = rfwd_pkg::HalfHiW;
  localparam int SqW   = rfwd_pkg::SqW;
  localparam int NormW = rfwd_pkg::NormW;
  localparam int RadW  = rfwd_pkg::RadW;
  localparam int MagW  = rfwd_pkg::MagW;

  // configuration registers
  rfwd_pkg::mode_t             decode_mode;
  logic [rfwd_pkg::AvgW-1:0]   averaged_spectra;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode      <= rfwd_pkg::MODE_SPEC;
      averaged_spectra <= rfwd_pkg::AvgW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfwd_pkg::CFG_IDX_MODE: decode_mode <= rfwd_pkg::mode_t'(cfg_data[1:0]);
        rfwd_pkg::CFG_IDX_AVG:  averaged_spectra <= cfg_data;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic en;
  logic out_vld;
  assign en         = !out_vld || result.ready;
  assign word.ready = en;

  // valid bits of the front stages
  logic p0_vld, p1_vld, p2_vld, p3_vld, p4_vld, p5_vld, p6_vld, p7_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0; p1_vld <= 1'b0; p2_vld <= 1'b0; p3_vld <= 1'b0;
      p4_vld <= 1'b0; p5_vld <= 1'b0; p6_vld <= 1'b0; p7_vld <= 1'b0;
    end else if (en) begin
      p0_vld <= word.valid;
      p1_vld <= p0_vld; p2_vld <= p1_vld; p3_vld <= p2_vld;
      p4_vld <= p3_vld; p5_vld <= p4_vld; p6_vld <= p5_vld; p7_vld <= p6_vld;
    end
  end

  // stage 0: capture request
  logic [31:0] p0_w, p0_w2;
  logic        p0_last;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_w    <= word.primary_word;
      p0_w2   <= word.secondary_word;
      p0_last <= word.end_of_spectrum;
    end
  end

  // stage 1: mantissa times average count
  logic [ProdW-1:0]   a_w, b_w;
  logic [ProdW-1:0]   p1_a, p1_b;
  logic [4:0]         p1_ea, p1_eb;
  rfwd_pkg::side_t    p1_side, p1_side_next;

  assign a_w = {13'b0, p0_w[31:6]} * {26'b0, averaged_spectra};
  assign b_w = {13'b0, p0_w2[31:6]} * {26'b0, averaged_spectra};

  always_comb begin
    p1_side_next        = '0;
    p1_side_next.last   = p0_last;
    p1_side_next.is_mag = decode_mode == rfwd_pkg::MODE_MAG;
    p1_side_next.neg    = (decode_mode == rfwd_pkg::MODE_CORR) && p0_w[5];
    if (decode_mode == rfwd_pkg::MODE_WAVE) begin
      p1_side_next.mag = {8'b0, p0_w};
      p1_side_next.e2  = -8'sd15;
    end else begin
      p1_side_next.mag = {1'b0, a_w};
      p1_side_next.e2  = 8'sd19 - $signed({3'b000, p0_w[4:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a    <= a_w;
      p1_b    <= b_w;
      p1_ea   <= p0_w[4:0];
      p1_eb   <= p0_w2[4:0];
      p1_side <= p1_side_next;
    end
  end

  // stage 2: partial products of both squares, common exponent
  logic [2*HiW-1:0]     p2_ahh, p2_bhh;
  logic [HiW+LoW-1:0]   p2_ahl, p2_bhl;
  logic [2*LoW-1:0]     p2_all, p2_bll;
  logic [5:0]           p2_sha, p2_shb;
  logic [4:0]           p2_k, k_w;
  rfwd_pkg::side_t      p2_side;

  assign k_w = (p1_ea > p1_eb) ? p1_ea : p1_eb;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ahh  <= {{HiW{1'b0}}, p1_a[ProdW-1:LoW]} * {{HiW{1'b0}}, p1_a[ProdW-1:LoW]};
      p2_ahl  <= {{LoW{1'b0}}, p1_a[ProdW-1:LoW]} * {{HiW{1'b0}}, p1_a[LoW-1:0]};
      p2_all  <= {{LoW{1'b0}}, p1_a[LoW-1:0]} * {{LoW{1'b0}}, p1_a[LoW-1:0]};
      p2_bhh  <= {{HiW{1'b0}}, p1_b[ProdW-1:LoW]} * {{HiW{1'b0}}, p1_b[ProdW-1:LoW]};
      p2_bhl  <= {{LoW{1'b0}}, p1_b[ProdW-1:LoW]} * {{HiW{1'b0}}, p1_b[LoW-1:0]};
      p2_bll  <= {{LoW{1'b0}}, p1_b[LoW-1:0]} * {{LoW{1'b0}}, p1_b[LoW-1:0]};
      p2_sha  <= {k_w - p1_ea, 1'b0};
      p2_shb  <= {k_w - p1_eb, 1'b0};
      p2_k    <= k_w;
      p2_side <= p1_side;
    end
  end

  // stage 3: assemble the squares
  logic [SqW-1:0]  p3_sqa, p3_sqb;
  logic [5:0]      p3_sha, p3_shb;
  logic [4:0]      p3_k;
  rfwd_pkg::side_t p3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sqa  <= {p2_ahh, {(2*LoW){1'b0}}}
               + {{(SqW-HiW-2*LoW-1){1'b0}}, p2_ahl, {(LoW+1){1'b0}}}
               + {{(SqW-2*LoW){1'b0}}, p2_all};
      p3_sqb  <= {p2_bhh, {(2*LoW){1'b0}}}
               + {{(SqW-HiW-2*LoW-1){1'b0}}, p2_bhl, {(LoW+1){1'b0}}}
               + {{(SqW-2*LoW){1'b0}}, p2_bll};
      p3_sha  <= p2_sha;
      p3_shb  <= p2_shb;
      p3_k    <= p2_k;
      p3_side <= p2_side;
    end
  end

  // stage 4: align both squares to the common exponent
  logic [NormW-1:0] p4_xa, p4_xb;
  logic [4:0]       p4_k;
  rfwd_pkg::side_t  p4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_xa   <= {{(NormW-SqW){1'b0}}, p3_sqa} << p3_sha;
      p4_xb   <= {{(NormW-SqW){1'b0}}, p3_sqb} << p3_shb;
      p4_k    <= p3_k;
      p4_side <= p3_side;
    end
  end

  // stage 5: sum of squares
  logic [NormW-1:0] p5_sum;
  logic [4:0]       p5_k;
  rfwd_pkg::side_t  p5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_sum  <= p4_xa + p4_xb;
      p5_k    <= p4_k;
      p5_side <= p4_side;
    end
  end

  // stage 6: leading zero search
  logic [NormW-1:0] p6_sum;
  logic [7:0]       p6_lz;
  logic [4:0]       p6_k;
  rfwd_pkg::side_t  p6_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p6_sum  <= p5_sum;
      p6_lz   <= rfwd_pkg::lzc_norm(p5_sum);
      p6_k    <= p5_k;
      p6_side <= p5_side;
    end
  end

  // stage 7: even normalize, take radicand window and sticky
  logic [NormW-1:0] norm_w;
  logic [RadW-1:0]  p7_rad;
  rfwd_pkg::side_t  p7_side, p7_side_next;

  assign norm_w = p6_sum << {p6_lz[7:1], 1'b0};

  always_comb begin
    p7_side_next = p6_side;
    if (p6_side.is_mag) begin
      p7_side_next.sticky = |norm_w[NormW-RadW-1:0];
      p7_side_next.e2     = 8'(rfwd_pkg::MagExpBase - int'(p6_lz[7:1]) - int'(p6_k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p7_rad  <= norm_w[NormW-1 -: RadW];
      p7_side <= p7_side_next;
    end
  end

  // square root pipeline
  logic                       sq_vld;
  logic [rfwd_pkg::RootW-1:0] sq_root;
  logic                       sq_rem_nz;
  rfwd_pkg::side_t            sq_side;

  rfwd_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (p7_vld),
    .in_rad     (p7_rad),
    .in_side    (p7_side),
    .out_valid  (sq_vld),
    .out_root   (sq_root),
    .out_rem_nz (sq_rem_nz),
    .out_side   (sq_side)
  );

  // packing stage 1: pick value to pack, find its length
  logic            q1_vld;
  logic [5:0]      q1_lz;
  logic            q1_zero;
  rfwd_pkg::side_t q1_side, q1_side_next;

  always_comb begin
    q1_side_next = sq_side;
    if (sq_side.is_mag) begin
      q1_side_next.mag    = {{(MagW-rfwd_pkg::RootW){1'b0}}, sq_root};
      q1_side_next.sticky = sq_side.sticky | sq_rem_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
    end else if (en) begin
      q1_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_side <= q1_side_next;
      q1_lz   <= rfwd_pkg::lzc_mag(q1_side_next.mag);
      q1_zero <= q1_side_next.mag == '0;
    end
  end

  // packing stage 2: normalize, round to nearest even, output register
  logic [MagW-1:0] pk_norm;
  logic            pk_up;
  logic [9:0]      pk_exp;
  logic [30:0]     pk_body;
  logic [31:0]     out_bits;
  logic            out_last;

  assign pk_norm = q1_side.mag << q1_lz;
  assign pk_up   = pk_norm[MagW-25] &
                   ((|pk_norm[MagW-26:0]) | q1_side.sticky | pk_norm[MagW-24]);
  assign pk_exp  = 10'(int'(q1_side.e2) + rfwd_pkg::ExpBias + MagW - 1 - int'(q1_lz));
  assign pk_body = {pk_exp[7:0], pk_norm[MagW-2 -: 23]} + 31'(pk_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bits <= q1_zero ? {q1_side.neg, 31'b0} : {q1_side.neg, pk_body};
      out_last <= q1_side.last;
    end
  end

  assign result.valid        = out_vld;
  assign result.float_bits   = out_bits;
  assign result.last_channel = out_last;

  // nonzero radicand of a magnitude request is normalized to its top two bits
  assert property (@(posedge clk) disable iff (rst)
    p7_vld && p7_side.is_mag && (p7_rad != '0) |-> p7_rad[RadW-1] || p7_rad[RadW-2])
    else $error("magnitude radicand not normalized");

  // nonzero square root always has its full width
  assert property (@(posedge clk) disable iff (rst)
    q1_vld && q1_side.is_mag && !q1_zero |-> q1_lz == 6'(MagW - rfwd_pkg::RootW))
    else $error("square root result lost its top bit");

endmodule
